[rtl/euler_camera_direction_macros.svh]
// assertion macros for the euler camera direction block
// used by the port checker, no other dependencies
`ifndef EULER_CAMERA_DIRECTION_MACROS_SVH
`define EULER_CAMERA_DIRECTION_MACROS_SVH

// checked property, disabled while in reset
`define ECD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked property, active during reset as well
`define ECD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

// q1.14 range of a result field while a request is shown
`define ECD_Q14_RANGE(lbl, sig) \
    `ECD_ASSERT(lbl, m_valid |-> ($signed(sig) <= 16384 && $signed(sig) >= -16384), "q14 range")

`endif

[rtl/ecd_pkg.sv]
// shared types, constants and functions of the euler camera direction block
// no dependencies
package ecd_pkg;

    localparam int ANG_W        = 16;
    localparam int Q_W          = 16;
    localparam int XY_W         = 34;
    localparam int Z_W          = 26;
    localparam int CORDIC_STEPS = 16;
    localparam int DIV_STEPS    = 15;
    localparam int STEP_W       = 4;
    localparam int T_W          = 14;
    localparam int QT_W         = 15;

    localparam logic signed [16:0] ANG_FULL    = 17'sd23040;
    localparam logic signed [16:0] ANG_HALF    = 17'sd11520;
    localparam logic signed [16:0] ANG_QUARTER = 17'sd5760;
    localparam logic signed [15:0] PITCH_LIMIT = 16'sd5696;
    localparam logic signed [15:0] Q14_ONE     = 16'sd16384;
    localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sd652032874;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   neg;
    } cordic_t;

    typedef struct packed {
        logic [T_W-1:0]  rem;
        logic [QT_W-1:0] lo;
        logic [QT_W-1:0] q;
        logic [T_W-1:0]  t;
        logic            neg;
    } div_t;

    typedef struct packed {
        logic signed [Q_W-1:0] fx;
        logic signed [Q_W-1:0] fy;
        logic signed [Q_W-1:0] fz;
        logic signed [Q_W-1:0] cr;
        logic signed [Q_W-1:0] sr;
        logic                  tiny;
        logic                  resc;
    } carry_t;

    function automatic logic signed [Z_W-1:0] atan_deg16(input logic [STEP_W-1:0] i);
        logic signed [Z_W-1:0] r;
        case (i)
            4'd0:    r = 26'sd2949120;
            4'd1:    r = 26'sd1740967;
            4'd2:    r = 26'sd919879;
            4'd3:    r = 26'sd466945;
            4'd4:    r = 26'sd234379;
            4'd5:    r = 26'sd117266;
            4'd6:    r = 26'sd58666;
            4'd7:    r = 26'sd29335;
            4'd8:    r = 26'sd14668;
            4'd9:    r = 26'sd7334;
            4'd10:   r = 26'sd3667;
            4'd11:   r = 26'sd1833;
            4'd12:   r = 26'sd917;
            4'd13:   r = 26'sd458;
            4'd14:   r = 26'sd229;
            4'd15:   r = 26'sd115;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [Q_W-1:0] sat_q14(input logic signed [17:0] v);
        logic signed [Q_W-1:0] r;
        if (v > 18'sd16384) begin
            r = Q14_ONE;
        end else if (v < -18'sd16384) begin
            r = -Q14_ONE;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

    // wrap to one turn, fold into the right half plane
    function automatic cordic_t reduce_angle(input logic signed [ANG_W-1:0] a);
        cordic_t         c;
        logic signed [16:0] w;
        logic signed [16:0] h;
        logic            n;
        w = {a[ANG_W-1], a};
        if (w >= ANG_HALF) begin
            w = w - ANG_FULL;
        end else if (w < -ANG_HALF) begin
            w = w + ANG_FULL;
        end
        n = 1'b0;
        h = w;
        if (w > ANG_QUARTER) begin
            h = w - ANG_HALF;
            n = 1'b1;
        end else if (w < -ANG_QUARTER) begin
            h = w + ANG_HALF;
            n = 1'b1;
        end
        c.x   = CORDIC_X0;
        c.y   = '0;
        c.z   = {h[Z_W-11:0], 10'd0};
        c.neg = n;
        return c;
    endfunction

endpackage

[rtl/ecd_cordic_cell.sv]
// one rotation step of the sine/cosine chain
// depends on ecd_pkg
module ecd_cordic_cell (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [ecd_pkg::STEP_W-1:0]    step_idx,
    input  ecd_pkg::cordic_t              din,
    output ecd_pkg::cordic_t              dout
);

    ecd_pkg::cordic_t dout_reg;
    ecd_pkg::cordic_t dout_next;
    logic signed [ecd_pkg::XY_W-1:0] xs;
    logic signed [ecd_pkg::XY_W-1:0] ys;
    logic signed [ecd_pkg::Z_W-1:0]  at;

    always_comb begin
        xs = din.x >>> step_idx;
        ys = din.y >>> step_idx;
        at = ecd_pkg::atan_deg16(step_idx);
        dout_next = din;
        if (!din.z[ecd_pkg::Z_W-1]) begin
            dout_next.x = din.x - ys;
            dout_next.y = din.y + xs;
            dout_next.z = din.z - at;
        end else begin
            dout_next.x = din.x + ys;
            dout_next.y = din.y - xs;
            dout_next.z = din.z + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

[rtl/ecd_div_cell.sv]
// one quotient bit of the restoring divider used for the l1 rescale
// depends on ecd_pkg
module ecd_div_cell (
    input  logic           aclk,
    input  logic           en,
    input  ecd_pkg::div_t  din,
    output ecd_pkg::div_t  dout
);

    ecd_pkg::div_t dout_reg;
    ecd_pkg::div_t dout_next;
    logic [ecd_pkg::T_W:0] r2;
    logic [ecd_pkg::T_W:0] diff;

    always_comb begin
        r2   = {din.rem, din.lo[ecd_pkg::QT_W-1]};
        diff = r2 - {1'b0, din.t};
        dout_next    = din;
        dout_next.lo = {din.lo[ecd_pkg::QT_W-2:0], 1'b0};
        if (r2 >= {1'b0, din.t}) begin
            dout_next.rem = diff[ecd_pkg::T_W-1:0];
            dout_next.q   = {din.q[ecd_pkg::QT_W-2:0], 1'b1};
        end else begin
            dout_next.rem = r2[ecd_pkg::T_W-1:0];
            dout_next.q   = {din.q[ecd_pkg::QT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

[rtl/euler_camera_direction.sv]
// top level of the euler camera direction block
// depends on ecd_pkg, ecd_cordic_cell, ecd_div_cell
//
//   channel  ports                                   direction
//   s_       s_valid s_ready yaw/pitch/roll angle    in
//   m_       m_valid m_ready front/up/flat fields    out
//
// one request per cycle while the pipeline is not held
// the pipeline has 16 rotation cells, 15 divider cells and 5 other stages
// aresetn clears the valid line only
// whole pipeline holds when the output register is full and m_ready is low
module euler_camera_direction (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_yaw_angle,
    input  logic [15:0] s_pitch_angle,
    input  logic [15:0] s_roll_angle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_front_x,
    output logic [15:0] m_front_y,
    output logic [15:0] m_front_z,
    output logic [15:0] m_up_x,
    output logic [15:0] m_up_y,
    output logic [15:0] m_flat_x,
    output logic [15:0] m_flat_z
);

    localparam int NSTG = ecd_pkg::CORDIC_STEPS + ecd_pkg::DIV_STEPS + 5;

    logic en;
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;

    assign en      = !valid_reg[NSTG-1] || m_ready;
    assign s_ready = en;
    assign m_valid = valid_reg[NSTG-1];

    always_comb begin
        valid_next = {valid_reg[NSTG-2:0], s_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    // angle reduction
    logic signed [15:0] pitch_c;
    ecd_pkg::cordic_t   cin_reg [3];

    always_comb begin
        pitch_c = $signed(s_pitch_angle);
        if (pitch_c > ecd_pkg::PITCH_LIMIT) begin
            pitch_c = ecd_pkg::PITCH_LIMIT;
        end else if (pitch_c < -ecd_pkg::PITCH_LIMIT) begin
            pitch_c = -ecd_pkg::PITCH_LIMIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cin_reg[0] <= ecd_pkg::reduce_angle($signed(s_yaw_angle));
            cin_reg[1] <= ecd_pkg::reduce_angle(pitch_c);
            cin_reg[2] <= ecd_pkg::reduce_angle($signed(s_roll_angle));
        end
    end

    // rotation chains: yaw, pitch, roll
    ecd_pkg::cordic_t cord [3][ecd_pkg::CORDIC_STEPS+1];

    for (genvar k = 0; k < 3; k++) begin : g_ch
        assign cord[k][0] = cin_reg[k];
        for (genvar i = 0; i < ecd_pkg::CORDIC_STEPS; i++) begin : g_cell
            ecd_cordic_cell u_cell (
                .aclk     (aclk),
                .en       (en),
                .step_idx (ecd_pkg::STEP_W'(i)),
                .din      (cord[k][i]),
                .dout     (cord[k][i+1])
            );
        end
    end

    // round to q1.14
    logic signed [15:0] cos_reg [3];
    logic signed [15:0] sin_reg [3];
    logic signed [15:0] cos_next [3];
    logic signed [15:0] sin_next [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [ecd_pkg::XY_W-1:0] xr;
            logic signed [ecd_pkg::XY_W-1:0] yr;
            logic signed [17:0] xq;
            logic signed [17:0] yq;
            xr = cord[k][ecd_pkg::CORDIC_STEPS].x + 34'sd32768;
            yr = cord[k][ecd_pkg::CORDIC_STEPS].y + 34'sd32768;
            xq = xr[33:16];
            yq = yr[33:16];
            if (cord[k][ecd_pkg::CORDIC_STEPS].neg) begin
                xq = -xq;
                yq = -yq;
            end
            cos_next[k] = ecd_pkg::sat_q14(xq);
            sin_next[k] = ecd_pkg::sat_q14(yq);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    // front vector products
    ecd_pkg::carry_t mul_reg;
    ecd_pkg::carry_t mul_next;
    logic signed [31:0] px;
    logic signed [31:0] pz;

    always_comb begin
        px = (cos_reg[0] * cos_reg[1]) + 32'sd8192;
        pz = (sin_reg[0] * cos_reg[1]) + 32'sd8192;
        mul_next      = '0;
        mul_next.fx   = ecd_pkg::sat_q14(px[31:14]);
        mul_next.fy   = sin_reg[1];
        mul_next.fz   = ecd_pkg::sat_q14(pz[31:14]);
        mul_next.cr   = cos_reg[2];
        mul_next.sr   = sin_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mul_reg <= mul_next;
        end
    end

    // l1 sum and divider set-up
    logic [14:0] ax;
    logic [14:0] az;
    logic [15:0] tsum;
    ecd_pkg::carry_t tc_next;
    ecd_pkg::div_t   dx_next;
    ecd_pkg::div_t   dz_next;

    always_comb begin
        ax   = mul_reg.fx[15] ? 15'(-mul_reg.fx) : mul_reg.fx[14:0];
        az   = mul_reg.fz[15] ? 15'(-mul_reg.fz) : mul_reg.fz[14:0];
        tsum = {1'b0, ax} + {1'b0, az};
        tc_next      = mul_reg;
        tc_next.tiny = tsum < 16'd2;
        tc_next.resc = tsum < 16'd16384;
        dx_next.rem  = ax[14:1];
        dx_next.lo   = {ax[0], 1'b0, tsum[13:1]};
        dx_next.q    = '0;
        dx_next.t    = tsum[13:0];
        dx_next.neg  = mul_reg.fx[15];
        dz_next.rem  = az[14:1];
        dz_next.lo   = {az[0], 1'b0, tsum[13:1]};
        dz_next.q    = '0;
        dz_next.t    = tsum[13:0];
        dz_next.neg  = mul_reg.fz[15];
    end

    ecd_pkg::carry_t carry_reg [ecd_pkg::DIV_STEPS+1];
    ecd_pkg::div_t   dvx [ecd_pkg::DIV_STEPS+1];
    ecd_pkg::div_t   dvz [ecd_pkg::DIV_STEPS+1];
    ecd_pkg::div_t   dx_reg;
    ecd_pkg::div_t   dz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            carry_reg[0] <= tc_next;
            dx_reg       <= dx_next;
            dz_reg       <= dz_next;
            for (int i = 1; i <= ecd_pkg::DIV_STEPS; i++) begin
                carry_reg[i] <= carry_reg[i-1];
            end
        end
    end

    assign dvx[0] = dx_reg;
    assign dvz[0] = dz_reg;

    for (genvar i = 0; i < ecd_pkg::DIV_STEPS; i++) begin : g_div
        ecd_div_cell u_dx (
            .aclk (aclk),
            .en   (en),
            .din  (dvx[i]),
            .dout (dvx[i+1])
        );
        ecd_div_cell u_dz (
            .aclk (aclk),
            .en   (en),
            .din  (dvz[i]),
            .dout (dvz[i+1])
        );
    end

    // output register
    ecd_pkg::carry_t    cf;
    logic signed [17:0] qx;
    logic signed [17:0] qz;
    logic signed [15:0] flx_next;
    logic signed [15:0] flz_next;
    logic [15:0] fx_reg, fy_reg, fz_reg, ux_reg, uy_reg, flx_reg, flz_reg;

    always_comb begin
        cf = carry_reg[ecd_pkg::DIV_STEPS];
        qx = {3'd0, dvx[ecd_pkg::DIV_STEPS].q};
        qz = {3'd0, dvz[ecd_pkg::DIV_STEPS].q};
        if (dvx[ecd_pkg::DIV_STEPS].neg) begin
            qx = -qx;
        end
        if (dvz[ecd_pkg::DIV_STEPS].neg) begin
            qz = -qz;
        end
        if (cf.tiny) begin
            flx_next = ecd_pkg::Q14_ONE;
            flz_next = cf.fz;
        end else if (cf.resc) begin
            flx_next = ecd_pkg::sat_q14(qx);
            flz_next = ecd_pkg::sat_q14(qz);
        end else begin
            flx_next = cf.fx;
            flz_next = cf.fz;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fx_reg  <= cf.fx;
            fy_reg  <= cf.fy;
            fz_reg  <= cf.fz;
            ux_reg  <= cf.cr;
            uy_reg  <= cf.sr;
            flx_reg <= flx_next;
            flz_reg <= flz_next;
        end
    end

    assign m_front_x = fx_reg;
    assign m_front_y = fy_reg;
    assign m_front_z = fz_reg;
    assign m_up_x    = ux_reg;
    assign m_up_y    = uy_reg;
    assign m_flat_x  = flx_reg;
    assign m_flat_z  = flz_reg;

endmodule

[rtl/ecd_checker.sv]
// port checker for the euler camera direction block, bound to the top level
// depends on euler_camera_direction_macros.svh
`include "euler_camera_direction_macros.svh"

module ecd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_front_x,
    input logic [15:0] m_flat_x
);

    `ECD_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "result after reset")
    `ECD_ASSERT(a_ready_rule, s_ready == (!m_valid || m_ready), "ready not tied to output room")
    `ECD_ASSERT(a_hold_valid, (m_valid && !m_ready) |=> m_valid, "result dropped")
    `ECD_Q14_RANGE(a_front_x_range, m_front_x)
    `ECD_Q14_RANGE(a_flat_x_range, m_flat_x)

endmodule

bind euler_camera_direction ecd_checker u_ecd_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_front_x (m_front_x),
    .m_flat_x  (m_flat_x)
);
